>>> design/ota_seq_pkg.sv
// Shared types and constants for the OTA packet sequencer.
// No dependencies; every other design file refers to this package by scoped names.
package ota_seq_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned PAYLOAD_ALIGN = 32;  // power of two

  typedef enum logic [1:0] {
    OP_HEADER     = 2'd0,
    OP_WRITE_DONE = 2'd1,
    OP_REINIT     = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE           = 3'd0,
    ST_RUNNING        = 3'd1,
    ST_DONE           = 3'd2,
    ST_LAST_DONE      = 3'd3,
    ST_CHECK_ERR      = 3'd4,
    ST_LAST_CHECK_ERR = 3'd5,
    ST_FAIL           = 3'd6,
    ST_LAST_FAIL      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_COMMIT  = 2'd1,
    ACT_RESTORE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_SLOT_A  = 2'd0,
    REG_SLOT_B  = 2'd1,
    REG_RUNNING = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [LEN_W-1:0] packet_length;
    logic [LEN_W-1:0] packet_index;
    logic [LEN_W-1:0] packet_total;
    logic             write_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              write_request;
    logic [ADDR_W-1:0] write_address;
    logic [LEN_W-1:0]  write_length;
    logic [1:0]        image_action;
    logic [ADDR_W-1:0] image_address;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slot_a;
    logic [ADDR_W-1:0] slot_b;
    logic [ADDR_W-1:0] running;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic              awaiting;
    logic              pending_last;
    logic [LEN_W-1:0]  pending_length;
    logic [LEN_W-1:0]  done_count;
    logic [LEN_W-1:0]  expected_total;
    logic [ADDR_W-1:0] next_address;
    logic              image_changed;
  } sess_t;

endpackage

>>> design/ota_seq_if.sv
// Valid/ready channel interfaces for packet items and result items.
// Depends on ota_seq_pkg for the payload types.
interface ota_seq_in_if;
  logic               valid;
  logic               ready;
  ota_seq_pkg::item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ota_seq_out_if;
  logic                 valid;
  logic                 ready;
  ota_seq_pkg::result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/ota_seq_step.sv
// Per-item session logic: next session state and optional result for one item.
// Purely combinational; depends on ota_seq_pkg.
module ota_seq_step (
  input  ota_seq_pkg::item_t   item,
  input  ota_seq_pkg::sess_t   cur,
  input  ota_seq_pkg::cfg_t    cfg,
  output ota_seq_pkg::sess_t   nxt,
  output ota_seq_pkg::result_t res,
  output logic                 has_result
);

  localparam logic [ota_seq_pkg::LEN_W-1:0] HDR =
    ota_seq_pkg::LEN_W'(ota_seq_pkg::HEADER_BYTES);
  localparam logic [ota_seq_pkg::LEN_W-1:0] ALIGN_MASK =
    ota_seq_pkg::LEN_W'(ota_seq_pkg::PAYLOAD_ALIGN - 1);

  logic [ota_seq_pkg::ADDR_W-1:0] target;
  logic [ota_seq_pkg::LEN_W-1:0]  payload;
  logic [ota_seq_pkg::LEN_W:0]    cnt_inc;
  logic                           start;
  logic                           last_cont;
  logic                           last;
  logic                           check_fail;
  logic                           hdr_take;

  assign target     = (cfg.running == cfg.slot_a) ? cfg.slot_b : cfg.slot_a;
  assign payload    = item.packet_length - HDR;
  assign cnt_inc    = {1'b0, cur.done_count} + 1'b1;
  assign start      = (cur.status == ota_seq_pkg::ST_IDLE) ||
                      (cur.status == ota_seq_pkg::ST_LAST_DONE);
  assign last_cont  = ({1'b0, cur.expected_total} == cnt_inc);
  assign last       = start ? (item.packet_total == ota_seq_pkg::LEN_W'(1)) : last_cont;
  assign check_fail = !start && ((item.packet_total != cur.expected_total) ||
                                 ({1'b0, item.packet_index} != cnt_inc) ||
                                 ((payload & ALIGN_MASK) != '0));
  assign hdr_take   = !cur.awaiting && (item.packet_length > HDR);

  always_comb begin
    nxt        = cur;
    res        = '0;
    has_result = 1'b0;
    case (item.opcode)
      ota_seq_pkg::OP_HEADER: begin
        if (hdr_take) begin
          has_result = 1'b1;
          if (check_fail) begin
            nxt.status = last_cont ? ota_seq_pkg::ST_LAST_CHECK_ERR
                                   : ota_seq_pkg::ST_CHECK_ERR;
            res.status = nxt.status;
            if (cur.image_changed) begin
              nxt.image_changed = 1'b0;
              res.image_action  = ota_seq_pkg::ACT_RESTORE;
              res.image_address = cfg.running;
            end
          end else begin
            if (start) begin
              nxt.expected_total = item.packet_total;
              nxt.done_count     = '0;
              nxt.next_address   = target;
            end
            nxt.status         = ota_seq_pkg::ST_RUNNING;
            nxt.awaiting       = 1'b1;
            nxt.pending_last   = last;
            nxt.pending_length = payload;
            res.status         = ota_seq_pkg::ST_RUNNING;
            res.write_request  = 1'b1;
            res.write_address  = start ? target : cur.next_address;
            res.write_length   = payload;
          end
        end
      end
      ota_seq_pkg::OP_WRITE_DONE: begin
        if (cur.awaiting) begin
          has_result   = 1'b1;
          nxt.awaiting = 1'b0;
          if (!item.write_ok) begin
            nxt.status = cur.pending_last ? ota_seq_pkg::ST_LAST_FAIL
                                          : ota_seq_pkg::ST_FAIL;
            res.status = nxt.status;
            if (cur.image_changed) begin
              nxt.image_changed = 1'b0;
              res.image_action  = ota_seq_pkg::ACT_RESTORE;
              res.image_address = cfg.running;
            end
          end else if (cur.pending_last) begin
            nxt.status         = ota_seq_pkg::ST_LAST_DONE;
            nxt.image_changed  = cur.image_changed || (target != cfg.running);
            nxt.next_address   = target;
            nxt.done_count     = '0;
            nxt.expected_total = '0;
            res.status         = ota_seq_pkg::ST_LAST_DONE;
            res.image_action   = ota_seq_pkg::ACT_COMMIT;
            res.image_address  = target;
          end else begin
            nxt.status       = ota_seq_pkg::ST_DONE;
            nxt.next_address = cur.next_address +
                               ota_seq_pkg::ADDR_W'(cur.pending_length);
            nxt.done_count   = cnt_inc[ota_seq_pkg::LEN_W-1:0];
            res.status       = ota_seq_pkg::ST_DONE;
          end
        end
      end
      ota_seq_pkg::OP_REINIT: begin
        nxt.status         = ota_seq_pkg::ST_IDLE;
        nxt.awaiting       = 1'b0;
        nxt.pending_last   = 1'b0;
        nxt.pending_length = '0;
        nxt.done_count     = '0;
        nxt.expected_total = '0;
        nxt.next_address   = target;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/ota_packet_sequencer.sv
// Top level of the OTA packet sequencer: input register, session state, result register.
// Depends on ota_seq_pkg, ota_seq_in_if/ota_seq_out_if and ota_seq_step.
//
//   channel   dir  handshake          payload
//   in_if     in   valid/ready        ota_seq_pkg::item_t
//   out_if    out  valid/ready        ota_seq_pkg::result_t
//   cfg_*     in   cfg_we, no ready   cfg_index, cfg_wdata
//
// One item per cycle while the input stage does not stall. An item is registered on
// transfer and resolved against the session registers; its result is then registered.
// Synchronous active-low reset clears valid flags, config and session state but not
// item or result data. The input stage keeps taking items while a result waits on
// out_if; it stalls only when it holds a result-producing item that cannot move.
module ota_packet_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  ota_seq_in_if.sink                     in_if,
  ota_seq_out_if.source                  out_if,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [ota_seq_pkg::ADDR_W-1:0] cfg_wdata
);

  ota_seq_pkg::cfg_t    cfg_r;
  ota_seq_pkg::sess_t   sess_r;
  ota_seq_pkg::sess_t   sess_nxt;
  ota_seq_pkg::item_t   item_r;
  logic                 item_valid_r;
  ota_seq_pkg::result_t out_data_r;
  logic                 out_valid_r;
  ota_seq_pkg::result_t step_res;
  logic                 step_has;
  logic                 item_fire;

  ota_seq_step u_step (
    .item       (item_r),
    .cur        (sess_r),
    .cfg        (cfg_r),
    .nxt        (sess_nxt),
    .res        (step_res),
    .has_result (step_has)
  );

  assign item_fire    = item_valid_r && (!step_has || !out_valid_r || out_if.ready);
  assign in_if.ready  = !item_valid_r || item_fire;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ota_seq_pkg::REG_SLOT_A:  cfg_r.slot_a  <= cfg_wdata;
        ota_seq_pkg::REG_SLOT_B:  cfg_r.slot_b  <= cfg_wdata;
        ota_seq_pkg::REG_RUNNING: cfg_r.running <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      item_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r <= in_if.data;
    end
  end

  // next_address after reset is the target base of all-zero registers, i.e. zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r <= '0;
    end else if (item_fire) begin
      sess_r <= sess_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_fire && step_has) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && step_has) begin
      out_data_r <= step_res;
    end
  end

  a_await_running: assert property (@(posedge clk) disable iff (!rst_n)
    sess_r.awaiting |-> (sess_r.status == ota_seq_pkg::ST_RUNNING))
    else $error("write pending outside running status");

  a_req_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.write_request) |->
      (out_data_r.status == ota_seq_pkg::ST_RUNNING))
    else $error("write request without running status");

  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.image_action == ota_seq_pkg::ACT_COMMIT)) |->
      (out_data_r.status == ota_seq_pkg::ST_LAST_DONE))
    else $error("image commit outside last done");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && step_has) |-> (!out_valid_r || out_if.ready))
    else $error("result register overwritten while held");

endmodule
